// ----- rtl/acsfc_pkg.sv -----
// Shared types, codes and frame constants of the air-conditioner serial frame codec.
`default_nettype none

package acsfc_pkg;

  typedef enum logic [1:0] {
    CMD_RX     = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_TX     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_VERDICT = 2'd2
  } kind_e;

  localparam int unsigned ImageLen = 16;
  localparam logic [5:0]  TxLastIdx = 6'd49;
  localparam logic [5:0]  SumLastIdx = 6'd47;
  localparam logic [5:0]  SumFirstIdx = 6'd2;
  localparam logic [7:0]  HdrByte = 8'h7e;
  localparam logic [7:0]  HdrTagByte = 8'h2f;
  localparam logic [7:0]  PrefixByte = 8'h01;
  localparam logic [7:0]  PendingFlag = 8'haf;
  localparam logic [7:0]  PostfixA = 8'h0c;
  localparam logic [7:0]  PostfixB = 8'h02;

  localparam logic [7:0] ImageRst [ImageLen] = '{
    8'h00, 8'h70, 8'h0a, 8'h02, 8'h10, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // controller -> datapath
  typedef struct packed {
    logic take_rx;
    logic take_update;
    logic take_tx;
    logic tx_step;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic tx_final;
  } dp_stat_t;

  // frame contents by index; the caller supplies the image byte and handles the checksum
  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic pending,
                                            input logic [7:0] img);
    logic [7:0] b;
    b = 8'h00;
    if (idx <= 6'd1) b = HdrByte;
    else if (idx == 6'd2) b = HdrTagByte;
    else if (idx == 6'd3) b = PrefixByte;
    else if (idx <= 6'd6) b = 8'h00;
    else if (idx == 6'd7) b = pending ? PendingFlag : 8'h00;
    else if (idx <= 6'd23) b = img;
    else if (idx == 6'd41) b = PostfixA;
    else if (idx == 6'd43) b = PostfixB;
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/acsfc_dp.sv -----
// Datapath: settings image, receive parser, frame generator and output register.
`default_nettype none

module acsfc_dp
  import acsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  input  wire logic [23:0] in_data_i,
  input  wire logic        m_tready_i,
  output logic             m_tvalid_o,
  output logic [23:0]      m_tdata_o,
  output logic [1:0]       m_tuser_o,
  output logic             m_tlast_o
);

  typedef enum logic [1:0] {
    RX_HUNT1 = 2'd0,
    RX_HUNT2 = 2'd1,
    RX_LEN   = 2'd2,
    RX_BODY  = 2'd3
  } rx_phase_e;

  logic [7:0] image_q [ImageLen];
  logic [7:0] shadow_q [ImageLen];
  rx_phase_e  rx_phase_q;
  logic [8:0] rx_rem_q;
  logic [8:0] rx_pos_q;
  logic       pending_q;
  logic [14:0] last_rep_q;
  logic [5:0] tx_idx_q;
  logic [7:0] tx_sum_q;

  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic [1:0]  out_kind_q;
  logic        out_last_q;

  // input fields
  logic [7:0] rx_byte;
  logic [3:0] w_mode;
  logic [5:0] w_temp;
  logic [3:0] w_fan;
  logic       w_swing;
  logic       w_light;
  assign rx_byte = in_data_i[7:0];
  assign w_mode  = in_data_i[11:8];
  assign w_temp  = in_data_i[17:12];
  assign w_fan   = in_data_i[21:18];
  assign w_swing = in_data_i[22];
  assign w_light = in_data_i[23];

  logic       upd_ok;
  logic [3:0] upd_mnib;
  logic [1:0] upd_fcode;
  assign upd_ok = (w_mode <= 4'd5) && (w_temp >= 6'd16) && (w_temp <= 6'd30)
               && (w_fan <= 4'd5);
  assign upd_mnib = (w_mode != 4'd0) ? (w_mode + 4'd7) : 4'd0;
  always_comb begin
    if (w_fan < 4'd3) upd_fcode = w_fan[1:0];
    else if (w_fan == 4'd3) upd_fcode = 2'd2;
    else upd_fcode = 2'd3;
  end

  // transmit byte
  logic [5:0] tx_idx_m8;
  logic [7:0] tx_b;
  logic       tx_in_sum;
  assign tx_idx_m8 = tx_idx_q - 6'd8;
  assign tx_b = (tx_idx_q == TxLastIdx) ? tx_sum_q
              : frame_byte(tx_idx_q, pending_q, image_q[tx_idx_m8[3:0]]);
  assign tx_in_sum = (tx_idx_q >= SumFirstIdx) && (tx_idx_q <= SumLastIdx);

  // receive body write index
  logic [8:0] rx_pos_m8;
  logic       rx_keep;
  assign rx_pos_m8 = rx_pos_q - 9'd8;
  assign rx_keep = (rx_pos_q >= 9'd8) && (rx_pos_q <= 9'd23);

  // decode of the committed shadow
  logic [3:0]  dec_nib;
  logic [3:0]  dec_mode;
  logic [4:0]  dec_temp;
  logic [3:0]  dec_fan;
  logic        dec_swing;
  logic        dec_light;
  logic [14:0] dec_packed;
  assign dec_nib   = shadow_q[0][7:4];
  assign dec_mode  = (dec_nib <= 4'd7) ? 4'd0 : (dec_nib - 4'd7);
  assign dec_temp  = {1'b1, shadow_q[1][7:4]};
  assign dec_fan   = shadow_q[14][3:0];
  assign dec_swing = |shadow_q[4][7:4];
  assign dec_light = shadow_q[2][1];
  assign dec_packed = {dec_light, dec_swing, dec_fan, dec_temp, dec_mode};

  logic rep_new;
  assign rep_new = cmd_i.commit && (dec_packed != last_rep_q);

  assign stat_o.out_free  = !out_valid_q || m_tready_i;
  assign stat_o.frame_end = (rx_phase_q == RX_BODY) && (rx_rem_q == 9'd1);
  assign stat_o.tx_final  = (tx_idx_q == TxLastIdx);

  // control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ImageLen; i++) image_q[i] <= ImageRst[i];
      rx_phase_q  <= RX_HUNT1;
      rx_rem_q    <= 9'd0;
      rx_pos_q    <= 9'd0;
      pending_q   <= 1'b0;
      last_rep_q  <= 15'd0;
      tx_idx_q    <= 6'd0;
      tx_sum_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_rx) begin
        case (rx_phase_q)
          RX_HUNT1: begin
            if (rx_byte == HdrByte) rx_phase_q <= RX_HUNT2;
          end
          RX_HUNT2: begin
            rx_phase_q <= (rx_byte == HdrByte) ? RX_LEN : RX_HUNT1;
          end
          RX_LEN: begin
            rx_rem_q   <= (rx_byte == 8'd0) ? 9'd256 : {1'b0, rx_byte};
            rx_pos_q   <= 9'd3;
            rx_phase_q <= RX_BODY;
          end
          RX_BODY: begin
            rx_pos_q <= rx_pos_q + 9'd1;
            rx_rem_q <= rx_rem_q - 9'd1;
            if (rx_rem_q == 9'd1) rx_phase_q <= RX_HUNT1;
          end
          default: rx_phase_q <= RX_HUNT1;
        endcase
      end

      if (cmd_i.take_update && upd_ok) begin
        image_q[0]  <= {upd_mnib, 2'b00, upd_fcode};
        image_q[1]  <= {w_temp[3:0], image_q[1][3:0]};
        image_q[2]  <= {image_q[2][7:2], w_light, image_q[2][0]};
        image_q[4]  <= {3'b000, w_swing, 4'h0};
        image_q[14] <= {4'h0, w_fan};
        pending_q   <= 1'b1;
      end

      if (cmd_i.commit) begin
        for (int i = 0; i < ImageLen; i++) image_q[i] <= shadow_q[i];
        if (rep_new) last_rep_q <= dec_packed;
      end

      if (cmd_i.take_tx) begin
        tx_idx_q   <= 6'd0;
        tx_sum_q   <= 8'd0;
        rx_phase_q <= RX_HUNT1;
        rx_rem_q   <= 9'd0;
        rx_pos_q   <= 9'd0;
      end

      if (cmd_i.tx_step) begin
        if (tx_in_sum) tx_sum_q <= tx_sum_q + tx_b;
        if (stat_o.tx_final) begin
          tx_idx_q  <= 6'd0;
          pending_q <= 1'b0;
        end else begin
          tx_idx_q <= tx_idx_q + 6'd1;
        end
      end

      if (cmd_i.take_update || cmd_i.tx_step || rep_new) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  // shadow image and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_rx && rx_phase_q == RX_LEN) begin
      for (int i = 0; i < ImageLen; i++) shadow_q[i] <= image_q[i];
    end else if (cmd_i.take_rx && rx_phase_q == RX_BODY && rx_keep) begin
      shadow_q[rx_pos_m8[3:0]] <= rx_byte;
    end

    if (cmd_i.take_update) begin
      out_data_q <= {upd_ok, 23'd0};
      out_kind_q <= KIND_VERDICT;
      out_last_q <= 1'b0;
    end else if (cmd_i.tx_step) begin
      out_data_q <= {16'd0, tx_b};
      out_kind_q <= KIND_TX;
      out_last_q <= stat_o.tx_final;
    end else if (rep_new) begin
      out_data_q <= {1'b0, dec_light, dec_swing, dec_fan, dec_temp, dec_mode, 8'd0};
      out_kind_q <= KIND_REPORT;
      out_last_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/acsfc_ctrl.sv -----
// Controller: one-hot state machine that sequences items, frame commit and transmit.
`default_nettype none

module acsfc_ctrl
  import acsfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_tvalid_i,
  input  wire logic [1:0] s_tuser_i,
  output logic            s_tready_o,
  input  wire dp_stat_t   stat_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_TX     = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   take;
  cmd_e   cmd;

  assign cmd        = cmd_e'(s_tuser_i);
  assign s_tready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign take       = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o = '0;
    if (take) begin
      case (cmd)
        CMD_RX:     cmd_o.take_rx = 1'b1;
        CMD_UPDATE: cmd_o.take_update = 1'b1;
        CMD_TX:     cmd_o.take_tx = 1'b1;
        default:    cmd_o = '0;
      endcase
    end
    cmd_o.tx_step = (state_q == ST_TX) && stat_i.out_free;
    cmd_o.commit  = (state_q == ST_COMMIT);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take_tx) state_d = ST_TX;
        else if (cmd_o.take_rx && stat_i.frame_end) state_d = ST_COMMIT;
      end
      ST_TX: begin
        if (cmd_o.tx_step && stat_i.tx_final) state_d = ST_IDLE;
      end
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

`default_nettype wire

// ----- rtl/aircon_serial_frame_codec.sv -----
// Top level of the air-conditioner serial frame codec.
//
// channel  dir  tdata fields (low bit up)                          tuser        tlast
// s_axis   in   rx_byte 8, want_mode 4, want_temp 6, want_fan 4,   command 2    -
//               want_swing 1, want_light 1
// m_axis   out  tx_byte 8, report_mode 4, report_temp 5,           result_kind  last_of_frame
//               report_fan 4, report_swing 1, report_light 1, accepted 1
//
// Received bytes and updates are handled as they are taken; a received byte that closes a frame
// leads to a commit state in which the report is decoded from the shadow image.
// A transmit item is accepted, then the generator emits the 50 frame bytes in order,
// each one when the output register is free.
// Input is held off while the output register holds an item that is not taken.
// Reset restores the default settings image and returns the receiver to hunting.
`default_nettype none

module aircon_serial_frame_codec
  import acsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // rx_byte, want_mode, want_temp, want_fan, swing, light
  input  wire logic [1:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // tx_byte, mode, temp, fan, swing, light, accepted
  output logic [1:0]       m_axis_tuser,  // result_kind
  output logic             m_axis_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  acsfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acsfc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // no item is taken while a result is blocked at the output
  a_ready_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input taken while output blocked");

  // only transmit bytes close a frame
  a_last_is_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_TX))
    else $error("tlast on a non-transmit item");

  // an update always yields its verdict in the next cycle
  a_update_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_UPDATE)
      |=> (m_axis_tvalid && m_axis_tuser == KIND_VERDICT))
    else $error("update verdict missing");

  // a transmit command blocks input on the following cycle
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TX) |=> !s_axis_tready)
    else $error("input taken during transmit");

endmodule

`default_nettype wire

// ----- tb/acsfc_link_checker.sv -----
// Checker for the serial frame codec: predicts link results and compares them with the output.
`timescale 1ns / 100ps

module acsfc_link_checker
  import acsfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [23:0] s_tdata_i,   // rx_byte, want_mode, want_temp, want_fan, swing, light
  input  wire logic [1:0]  s_tuser_i,   // command
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [23:0] m_tdata_i,   // tx_byte, mode, temp, fan, swing, light, accepted
  input  wire logic [1:0]  m_tuser_i,   // result_kind
  input  wire logic        m_tlast_i,
  output int               error_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] txb;
    logic       last;
    logic [3:0] md;
    logic [4:0] tp;
    logic [3:0] fn;
    logic       sw;
    logic       lt;
    logic       acc;
  } link_result_t;

  typedef enum logic [1:0] {
    RxHunt,
    RxHdr2,
    RxLen,
    RxBody
  } rx_phase_e;

  link_result_t expected_q[$];

  logic [7:0]  image [ImageLen];
  logic [7:0]  shadow [ImageLen];
  rx_phase_e   rx_state;
  logic [8:0]  rx_left;
  logic [8:0]  rx_pos;
  logic        upd_pending;
  logic [14:0] shown_state;

  function automatic string show(input link_result_t r);
    return $sformatf({"kind=%0d byte=%02h last=%0b mode=%0d temp=%0d fan=%0d ",
                      "swing=%0b light=%0b acc=%0b"},
                     r.kind, r.txb, r.last, r.md, r.tp, r.fn, r.sw, r.lt, r.acc);
  endfunction

  function automatic logic [7:0] link_frame_byte(input logic [5:0] idx);
    logic [5:0] off;
    off = idx - 6'd8;
    if (idx < 6'd2) return HdrByte;
    if (idx == 6'd2) return HdrTagByte;
    if (idx == 6'd3) return PrefixByte;
    if (idx == 6'd7) return upd_pending ? PendingFlag : 8'h00;
    if (idx >= 6'd8 && idx <= 6'd23) return image[off[3:0]];
    if (idx == 6'd41) return PostfixA;
    if (idx == 6'd43) return PostfixB;
    return 8'h00;
  endfunction

  task automatic push_result(input logic [1:0] kind, input logic [7:0] txb, input logic last,
                             input logic [3:0] md, input logic [4:0] tp, input logic [3:0] fn,
                             input logic sw, input logic lt, input logic acc);
    link_result_t r;
    r = '{kind: kind, txb: txb, last: last, md: md, tp: tp, fn: fn, sw: sw, lt: lt, acc: acc};
    expected_q.push_back(r);
  endtask

  task automatic reset_model();
    for (int i = 0; i < ImageLen; i++) begin
      image[i] = ImageRst[i];
      shadow[i] = 8'h00;
    end
    rx_state = RxHunt;
    rx_left = '0;
    rx_pos = '0;
    upd_pending = 1'b0;
    shown_state = '0;
    expected_q.delete();
  endtask

  task automatic emit_frame();
    logic [7:0] sum;
    logic [7:0] b;
    logic [5:0] idx;
    sum = 8'h00;
    for (int i = 0; i <= int'(TxLastIdx); i++) begin
      idx = 6'(i);
      if (idx == TxLastIdx) begin
        b = sum;
      end else begin
        b = link_frame_byte(idx);
        if (idx >= SumFirstIdx && idx <= SumLastIdx) sum = sum + b;
      end
      push_result(KIND_TX, b, idx == TxLastIdx, 4'd0, 5'd0, 4'd0, 1'b0, 1'b0, 1'b0);
    end
    // transmit drops any frame in progress
    upd_pending = 1'b0;
    rx_state = RxHunt;
    rx_left = '0;
    rx_pos = '0;
  endtask

  task automatic apply_update(input logic [3:0] md, input logic [5:0] tp, input logic [3:0] fn,
                              input logic sw, input logic lt);
    logic       ok;
    logic [3:0] mnib;
    logic [3:0] fcode;
    logic [5:0] toff;
    ok = (md <= 4'd5) && (tp >= 6'd16) && (tp <= 6'd30) && (fn <= 4'd5);
    if (ok) begin
      mnib = (md != 4'd0) ? md + 4'd7 : 4'd0;
      if (fn < 4'd3) fcode = fn;
      else if (fn == 4'd3) fcode = 4'd2;
      else fcode = 4'd3;
      toff = tp - 6'd16;
      image[0] = {mnib, fcode};
      image[1] = {toff[3:0], image[1][3:0]};
      image[2][1] = lt;
      image[4] = {3'b000, sw, 4'h0};
      image[14] = {4'h0, fn};
      upd_pending = 1'b1;
    end
    push_result(KIND_VERDICT, 8'h00, 1'b0, 4'd0, 5'd0, 4'd0, 1'b0, 1'b0, ok);
  endtask

  task automatic commit_frame();
    logic [3:0]  nib;
    logic [3:0]  md;
    logic [4:0]  tp;
    logic [3:0]  fn;
    logic        sw;
    logic        lt;
    logic [14:0] decoded;
    image = shadow;
    rx_state = RxHunt;
    nib = image[0][7:4];
    md = (nib <= 4'd7) ? 4'd0 : nib - 4'd7;
    tp = {1'b0, image[1][7:4]} + 5'd16;
    fn = image[14][3:0];
    sw = |image[4][7:4];
    lt = image[2][1];
    decoded = {lt, sw, fn, tp, md};
    // reported only on change
    if (decoded != shown_state) begin
      shown_state = decoded;
      push_result(KIND_REPORT, 8'h00, 1'b0, md, tp, fn, sw, lt, 1'b0);
    end
  endtask

  task automatic take_link_byte(input logic [7:0] c);
    logic [8:0] off;
    case (rx_state)
      RxHunt: if (c == HdrByte) rx_state = RxHdr2;
      RxHdr2: rx_state = (c == HdrByte) ? RxLen : RxHunt;
      RxLen: begin
        rx_left = (c == 8'h00) ? 9'd256 : {1'b0, c};
        rx_pos = 9'd3;
        shadow = image;
        rx_state = RxBody;
      end
      default: begin
        if (rx_pos >= 9'd8 && rx_pos <= 9'd23) begin
          off = rx_pos - 9'd8;
          shadow[off[3:0]] = c;
        end
        rx_pos = rx_pos + 9'd1;
        rx_left = rx_left - 9'd1;
        if (rx_left == 9'd0) commit_frame();
      end
    endcase
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [23:0] d);
    case (cmd)
      CMD_RX:     take_link_byte(d[7:0]);
      CMD_UPDATE: apply_update(d[11:8], d[17:12], d[21:18], d[22], d[23]);
      CMD_TX:     emit_frame();
      default: ;
    endcase
  endtask

  task automatic check_result();
    link_result_t got;
    link_result_t want;
    got = '{kind: m_tuser_i, txb: m_tdata_i[7:0], last: m_tlast_i, md: m_tdata_i[11:8],
            tp: m_tdata_i[16:12], fn: m_tdata_i[20:17], sw: m_tdata_i[21], lt: m_tdata_i[22],
            acc: m_tdata_i[23]};
    if (expected_q.size() == 0) begin
      error_count_o++;
      if (error_count_o <= 10) $display("chk: result with nothing expected: %s", show(got));
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.txb !== want.txb || got.last !== want.last ||
          got.md !== want.md || got.tp !== want.tp || got.fn !== want.fn ||
          got.sw !== want.sw || got.lt !== want.lt || got.acc !== want.acc) begin
        error_count_o++;
        if (error_count_o <= 10) begin
          $display("chk: mismatch at %0t", $realtime);
          $display("chk:   expected %s", show(want));
          $display("chk:   actual   %s", show(got));
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      pending_o = 0;
    end else begin
      // a result always comes from an earlier item, so check before predicting
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) predict_item(s_tuser_i, s_tdata_i);
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the serial frame codec: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb
  import acsfc_pkg::*;
();

  localparam logic [1:0] CmdIgnored = 2'd3;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 60;
  localparam int MixBudget = 22;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_ready = 1'b0;
  wire logic        s_ready;
  wire logic        m_valid;
  wire logic [23:0] m_data;
  wire logic [1:0]  m_user;
  wire logic        m_last;

  int chk_errors;
  int chk_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  aircon_serial_frame_codec uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last)
  );

  acsfc_link_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_valid),
    .s_tready_i   (s_ready),
    .s_tdata_i    (s_data),
    .s_tuser_i    (s_user),
    .m_tvalid_i   (m_valid),
    .m_tready_i   (m_ready),
    .m_tdata_i    (m_data),
    .m_tuser_i    (m_user),
    .m_tlast_i    (m_last),
    .error_count_o(chk_errors),
    .pending_o    (chk_pending)
  );

  // receiver: random stalls, plus a long hold-off each time hold_seq moves
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer(input logic [1:0] cmd, input logic [23:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= d;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_rx(input logic [7:0] b);
    logic [23:0] d;
    d = 24'($urandom);
    d[7:0] = b;
    offer(CMD_RX, d);
  endtask

  task automatic send_update(input logic [3:0] md, input logic [5:0] tp, input logic [3:0] fn,
                             input logic sw, input logic lt);
    logic [7:0] junk;
    junk = 8'($urandom);
    offer(CMD_UPDATE, {lt, sw, fn, tp, md, junk});
  endtask

  task automatic send_tx();
    logic [23:0] d;
    d = 24'($urandom);
    offer(CMD_TX, d);
  endtask

  task automatic send_ignored();
    logic [23:0] d;
    d = 24'($urandom);
    offer(CmdIgnored, d);
  endtask

  task automatic send_random_update();
    if ($urandom_range(3) != 0)
      send_update(4'($urandom_range(0, 5)), 6'($urandom_range(16, 30)),
                  4'($urandom_range(0, 5)), 1'($urandom), 1'($urandom));
    else
      send_update(4'($urandom), 6'($urandom), 4'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // len 0 stands for 256 payload bytes
  task automatic send_frame(input logic [7:0] len);
    int n;
    logic [7:0] b;
    n = (len == 8'h00) ? 256 : int'(len);
    send_rx(HdrByte);
    send_rx(HdrByte);
    send_rx(len);
    repeat (n) begin
      b = 8'($urandom);
      send_rx(b);
    end
  endtask

  task automatic run_mix(input int budget);
    int start;
    int pick;
    logic [7:0] len;
    logic [7:0] b;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = int'($urandom_range(99));
      if (pick < 45) begin
        if ($urandom_range(9) == 0) len = 8'($urandom_range(31, 60));
        else len = 8'($urandom_range(1, 30));
        send_frame(len);
      end else if (pick < 65) begin
        send_random_update();
      end else if (pick < 72) begin
        send_tx();
      end else if (pick < 80) begin
        // broken header
        b = 8'($urandom);
        if (b == HdrByte) b = 8'h00;
        send_rx(HdrByte);
        send_rx(b);
      end else if (pick < 87) begin
        // frame cut short by a transmit
        len = 8'($urandom_range(6, 40));
        send_rx(HdrByte);
        send_rx(HdrByte);
        send_rx(len);
        repeat ($urandom_range(0, int'(len) - 1)) begin
          b = 8'($urandom);
          send_rx(b);
        end
        send_tx();
      end else if (pick < 92) begin
        send_ignored();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom);
          send_rx(b);
        end
      end
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    @(negedge clk);
    while (chk_pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: unknown command, rejected and edge updates, pending flag in the frame
    send_ignored();
    send_update(4'hf, 6'h3f, 4'hf, 1'b1, 1'b1);
    send_update(4'd5, 6'd30, 4'd5, 1'b1, 1'b1);
    send_update(4'd0, 6'd16, 4'd0, 1'b0, 1'b0);
    send_tx();
    // one-byte frames: the second decodes the same state and stays silent
    send_rx(HdrByte); send_rx(HdrByte); send_rx(8'h01); send_rx(8'hff);
    send_rx(HdrByte); send_rx(HdrByte); send_rx(8'h01); send_rx(8'h00);
    send_rx(HdrByte); send_rx(8'h00);
    // transmit drops the partial frame
    send_rx(HdrByte); send_rx(HdrByte); send_rx(8'h05); send_rx(8'haa); send_rx(8'h55);
    send_tx();

    // long receiver hold-off while the sender keeps going
    hold_seq <= hold_seq + 1;
    send_tx();
    run_mix(MixBudget);
    drain();

    send_idle_pct = 73;
    run_mix(MixBudget);
    drain();

    send_idle_pct = 0;
    recv_stall_pct <= 73;
    run_mix(MixBudget);
    drain();

    send_idle_pct = 18;
    recv_stall_pct <= 18;
    send_frame(8'h00);
    run_mix(MixBudget);
    drain();

    repeat (SettleCycles) @(negedge clk);
    if (chk_errors == 0 && chk_pending == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
